### rtl/rbgm_pkg.sv
// ----------------------------------------------------------------------------
// rbgm_pkg
// Shared types and codes of the region border glow map.
// ----------------------------------------------------------------------------
package rbgm_pkg;

	localparam logic [1:0] ACT_PALETTE = 2'd0;
	localparam logic [1:0] ACT_WRITE   = 2'd1;
	localparam logic [1:0] ACT_COMPUTE = 2'd2;
	localparam logic [1:0] ACT_READ    = 2'd3;

	localparam logic [2:0] REG_MAP_SIZE      = 3'd0;
	localparam logic [2:0] REG_ALPHA_MAX     = 3'd1;
	localparam logic [2:0] REG_ALPHA_FALLOFF = 3'd2;
	localparam logic [2:0] REG_OWNER_MASK    = 3'd3;
	localparam logic [2:0] REG_PLAYER_COUNT  = 3'd4;

	localparam logic [8:0] RST_MAP_SIZE      = 9'd256;
	localparam logic [7:0] RST_ALPHA_MAX     = 8'hC0;
	localparam logic [7:0] RST_ALPHA_FALLOFF = 8'h20;
	localparam logic [7:0] RST_OWNER_MASK    = 8'd31;
	localparam logic [5:0] RST_PLAYER_COUNT  = 6'd0;

	localparam logic [23:0] COLOR_MAGENTA = 24'hFF00FF;

	typedef struct packed {
		logic [7:0] alpha_max;
		logic [7:0] alpha_falloff;
		logic [7:0] owner_mask;
	} cfg_t;

endpackage

### rtl/region_border_glow_map.sv
// ----------------------------------------------------------------------------
// region_border_glow_map
// Territory border glow overlay with owner grid, palette and alpha map.
// ----------------------------------------------------------------------------
// A pixel read goes through the owner/alpha memory read and then the palette
// read, and the next word is taken once the result has left the output
// register. A compute runs border marking (five owner memory reads per cell
// through its single read port), then the row sweeps, the column sweeps and
// the final pass, each over the active side. After reset the alpha memory is
// cleared, during which no word is taken.
module region_border_glow_map #(
	parameter int MAX_SIDE    = 256,
	parameter int MAX_PLAYERS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  cell_x,
	input  logic [7:0]  cell_y,
	input  logic [7:0]  cell_owner,
	input  logic [4:0]  palette_index,
	input  logic [23:0] color_rgb,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha
);
	import rbgm_pkg::*;

	localparam int SW   = $clog2(MAX_SIDE + 1);
	localparam int DAW  = $clog2(MAX_SIDE * MAX_SIDE);
	localparam int PW   = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1;
	localparam int MW   = (SW > 9) ? SW : 9;
	localparam int CW   = (SW > 8) ? SW : 8;
	localparam int OW   = (PW > 8) ? PW + 1 : 9;

	logic [8:0] map_size_q;
	logic [7:0] alpha_max_q, alpha_falloff_q, owner_mask_q;
	logic [5:0] player_count_q;
	cfg_t       cfg;

	logic [SW-1:0] side;
	logic          cfg_wr, acc;
	logic          eng_busy, eng_start;
	logic [DAW-1:0] eng_own_raddr, eng_alp_raddr, alp_waddr, px_addr;
	logic [DAW-1:0] own_raddr, alp_raddr;
	logic [7:0]    own_rdata, alp_rdata, alp_wdata;
	logic          alp_we;
	logic          own_we, pal_we, in_store, in_map;
	logic [PW-1:0] pal_waddr, pal_raddr;
	logic [23:0]   pal_rdata;
	logic [7:0]    own_m;

	logic          v_s1, inb_s1;
	logic          v_s2, inb_s2, col_ok_s2;
	logic [7:0]    alpha_s2;
	logic          out_valid_q;
	logic [7:0]    red_q, green_q, blue_q, alpha_q;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_size_q      <= RST_MAP_SIZE;
			alpha_max_q     <= RST_ALPHA_MAX;
			alpha_falloff_q <= RST_ALPHA_FALLOFF;
			owner_mask_q    <= RST_OWNER_MASK;
			player_count_q  <= RST_PLAYER_COUNT;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_MAP_SIZE:      map_size_q      <= pwdata[8:0];
				REG_ALPHA_MAX:     alpha_max_q     <= pwdata[7:0];
				REG_ALPHA_FALLOFF: alpha_falloff_q <= pwdata[7:0];
				REG_OWNER_MASK:    owner_mask_q    <= pwdata[7:0];
				REG_PLAYER_COUNT:  player_count_q  <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_MAP_SIZE:      prdata = {23'd0, map_size_q};
			REG_ALPHA_MAX:     prdata = {24'd0, alpha_max_q};
			REG_ALPHA_FALLOFF: prdata = {24'd0, alpha_falloff_q};
			REG_OWNER_MASK:    prdata = {24'd0, owner_mask_q};
			REG_PLAYER_COUNT:  prdata = {26'd0, player_count_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.alpha_max     = alpha_max_q;
	assign cfg.alpha_falloff = alpha_falloff_q;
	assign cfg.owner_mask    = owner_mask_q;

	// A side of zero acts as one; anything above the store acts as the store.
	always_comb begin
		if (map_size_q == 9'd0) begin
			side = SW'(1);
		end else if (MW'(map_size_q) > MW'(MAX_SIDE)) begin
			side = SW'(MAX_SIDE);
		end else begin
			side = SW'(map_size_q);
		end
	end

	// Input side.
	assign in_stall  = eng_busy | v_s1 | v_s2 | (out_valid_q & out_stall);
	assign acc       = in_valid & ~in_stall;
	assign eng_start = acc & (action == ACT_COMPUTE);
	assign in_store  = (CW'(cell_x) < CW'(MAX_SIDE)) && (CW'(cell_y) < CW'(MAX_SIDE));
	assign in_map    = (CW'(cell_x) < CW'(side)) && (CW'(cell_y) < CW'(side));
	assign px_addr   = DAW'(cell_y) * DAW'(MAX_SIDE) + DAW'(cell_x);
	assign own_we    = acc & (action == ACT_WRITE) & in_store;
	assign pal_we    = acc & (action == ACT_PALETTE) &
	                   (OW'(palette_index) < OW'(MAX_PLAYERS));
	assign pal_waddr = PW'(palette_index);
	assign own_raddr = eng_busy ? eng_own_raddr : px_addr;
	assign alp_raddr = eng_busy ? eng_alp_raddr : px_addr;

	assign own_m     = own_rdata & owner_mask_q;
	assign pal_raddr = PW'(own_m);

	rbgm_ram #(.WIDTH(8), .DEPTH(MAX_SIDE * MAX_SIDE)) u_owner_ram (
		.clk   (clk),
		.we    (own_we),
		.waddr (px_addr),
		.wdata (cell_owner),
		.raddr (own_raddr),
		.rdata (own_rdata)
	);

	rbgm_ram #(.WIDTH(8), .DEPTH(MAX_SIDE * MAX_SIDE)) u_alpha_ram (
		.clk   (clk),
		.we    (alp_we),
		.waddr (alp_waddr),
		.wdata (alp_wdata),
		.raddr (alp_raddr),
		.rdata (alp_rdata)
	);

	rbgm_ram #(.WIDTH(24), .DEPTH(MAX_PLAYERS)) u_palette_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_waddr),
		.wdata (color_rgb),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	rbgm_engine #(.MAX_SIDE(MAX_SIDE)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (eng_start),
		.side      (side),
		.cfg       (cfg),
		.busy      (eng_busy),
		.own_raddr (eng_own_raddr),
		.own_rdata (own_rdata),
		.alp_raddr (eng_alp_raddr),
		.alp_rdata (alp_rdata),
		.alp_we    (alp_we),
		.alp_waddr (alp_waddr),
		.alp_wdata (alp_wdata)
	);

	// Pixel read pipeline: owner and alpha land in s1, palette in s2.
	always_ff @(posedge clk) begin
		inb_s1    <= in_map;
		inb_s2    <= inb_s1;
		alpha_s2  <= alp_rdata;
		col_ok_s2 <= (own_m < {2'b00, player_count_q}) && (OW'(own_m) < OW'(MAX_PLAYERS));
		if (v_s2) begin
			if (!inb_s2) begin
				{red_q, green_q, blue_q} <= '0;
				alpha_q <= '0;
			end else begin
				{red_q, green_q, blue_q} <= col_ok_s2 ? pal_rdata : COLOR_MAGENTA;
				alpha_q <= alpha_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= acc & (action == ACT_READ);
			v_s2 <= v_s1;
			if (v_s2) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign alpha     = alpha_q;

	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> v_s2 && !v_s1)
		else $error("read word did not advance to palette stage");
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |=> out_valid_q)
		else $error("read word did not reach output register");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> !v_s1 && !v_s2 && !eng_busy)
		else $error("word taken while read or compute in flight");

endmodule

### rtl/rbgm_ram.sv
// ----------------------------------------------------------------------------
// rbgm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rbgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/rbgm_engine.sv
// ----------------------------------------------------------------------------
// rbgm_engine
// Sequencer that clears the alpha memory after reset and runs the compute:
// border marking, row and column sweeps, and the final alpha_max knockout.
// ----------------------------------------------------------------------------
module rbgm_engine #(
	parameter int MAX_SIDE = 256,
	parameter int SW       = $clog2(MAX_SIDE + 1),
	parameter int DAW      = $clog2(MAX_SIDE * MAX_SIDE)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SW-1:0]     side,
	input  rbgm_pkg::cfg_t    cfg,
	output logic              busy,
	output logic [DAW-1:0]    own_raddr,
	input  logic [7:0]        own_rdata,
	output logic [DAW-1:0]    alp_raddr,
	input  logic [7:0]        alp_rdata,
	output logic              alp_we,
	output logic [DAW-1:0]    alp_waddr,
	output logic [7:0]        alp_wdata
);
	import rbgm_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EDGE  = 2'd2;
	localparam logic [1:0] ST_SWEEP = 2'd3;

	localparam logic [1:0] PASS_ROW = 2'd0;
	localparam logic [1:0] PASS_COL = 2'd1;
	localparam logic [1:0] PASS_FIN = 2'd2;

	localparam logic [2:0] STEP_LAST = 3'd5;

	logic [1:0]     state_q;
	logic [DAW-1:0] clr_q;
	logic [SW-1:0]  x_q, y_q, l_q, k_q;
	logic [2:0]     step_q;
	logic [7:0]     cen_q;
	logic           edge_q;
	logic [1:0]     pass_q;
	logic           dir_q;
	logic [7:0]     a_q;
	logic [DAW-1:0] addr_s1;

	logic [SW-1:0]  nx, ny, pos, sw_x, sw_y;
	logic [7:0]     own_m;
	logic           edge_fin;
	logic [8:0]     dec;
	logic [7:0]     a_next;

	function automatic logic [DAW-1:0] cell_addr(input logic [SW-1:0] cx,
			input logic [SW-1:0] cy);
		cell_addr = DAW'(cy) * DAW'(MAX_SIDE) + DAW'(cx);
	endfunction

	always_comb begin
		nx = x_q;
		ny = y_q;
		case (step_q)
			3'd1: if (x_q != '0) nx = x_q - 1'b1;
			3'd2: if (x_q + 1'b1 < side) nx = x_q + 1'b1;
			3'd3: if (y_q != '0) ny = y_q - 1'b1;
			3'd4: if (y_q + 1'b1 < side) ny = y_q + 1'b1;
			default: ;
		endcase
		own_raddr = cell_addr(nx, ny);
		own_m     = own_rdata & cfg.owner_mask;
		edge_fin  = edge_q | (own_m != cen_q);

		pos  = dir_q ? SW'(side - k_q - 1'b1) : k_q;
		sw_x = (pass_q == PASS_COL) ? l_q : pos;
		sw_y = (pass_q == PASS_COL) ? pos : l_q;
		alp_raddr = cell_addr(sw_x, sw_y);

		// Decay toward the running peak, floored at the stored value.
		dec = {1'b0, a_q} - {1'b0, cfg.alpha_falloff};
		if (!dec[8] && dec[7:0] > alp_rdata) begin
			a_next = dec[7:0];
		end else begin
			a_next = alp_rdata;
		end

		alp_we    = 1'b0;
		alp_waddr = addr_s1;
		alp_wdata = a_next;
		case (state_q)
			ST_CLEAR: begin
				alp_we    = 1'b1;
				alp_waddr = clr_q;
				alp_wdata = '0;
			end
			ST_EDGE: begin
				alp_we    = (step_q == STEP_LAST);
				alp_waddr = cell_addr(x_q, y_q);
				alp_wdata = edge_fin ? cfg.alpha_max : 8'd0;
			end
			ST_SWEEP: begin
				alp_we = (k_q != '0);
				if (pass_q == PASS_FIN) begin
					alp_wdata = (alp_rdata == cfg.alpha_max) ? 8'd0 : alp_rdata;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk) begin
		addr_s1 <= alp_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			l_q     <= '0;
			k_q     <= '0;
			step_q  <= '0;
			cen_q   <= '0;
			edge_q  <= 1'b0;
			pass_q  <= PASS_ROW;
			dir_q   <= 1'b0;
			a_q     <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == DAW'(MAX_SIDE * MAX_SIDE - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EDGE;
						x_q     <= '0;
						y_q     <= '0;
						step_q  <= '0;
					end
				end
				ST_EDGE: begin
					// Reads go out on steps 0..4; their data is registered and used on steps 1..5.
					if (step_q == 3'd1) begin
						cen_q  <= own_m;
						edge_q <= (own_m == 8'd0);
					end else if (step_q != 3'd0) begin
						edge_q <= edge_fin;
					end
					if (step_q == STEP_LAST) begin
						step_q <= '0;
						if (x_q == side - 1'b1) begin
							x_q <= '0;
							if (y_q == side - 1'b1) begin
								state_q <= ST_SWEEP;
								pass_q  <= PASS_ROW;
								dir_q   <= 1'b0;
								l_q     <= '0;
								k_q     <= '0;
								a_q     <= '0;
							end else begin
								y_q <= y_q + 1'b1;
							end
						end else begin
							x_q <= x_q + 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SWEEP: begin
					if (k_q != side) begin
						k_q <= k_q + 1'b1;
						if (k_q != '0) a_q <= a_next;
					end else begin
						k_q <= '0;
						a_q <= '0;
						if (pass_q != PASS_FIN && !dir_q) begin
							dir_q <= 1'b1;
						end else begin
							dir_q <= 1'b0;
							if (l_q == side - 1'b1) begin
								l_q <= '0;
								case (pass_q)
									PASS_ROW: pass_q  <= PASS_COL;
									PASS_COL: pass_q  <= PASS_FIN;
									default:  state_q <= ST_IDLE;
								endcase
							end else begin
								l_q <= l_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_edge_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EDGE |-> step_q <= STEP_LAST)
		else $error("edge step counter out of range");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("compute started while engine busy");
	a_sweep_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> k_q <= side)
		else $error("sweep position beyond side");

endmodule
